[sv/elnm_pkg.sv]
// elnm_pkg: shared types and constants of the event neuron map
// holds the decay table, energy format constants, register indexes and
// the command and status structs between controller and datapath
`timescale 1ns / 1ps

package elnm_pkg;

    localparam int STAMP_W = 24;
    localparam int EN_W = 16;
    localparam int POS_W = 9;
    localparam int THR_W = 16;
    localparam int TAU_W = 32;
    localparam int FSZ_W = 4;
    localparam int FACT_W = 33;
    localparam int SCALE_W = STAMP_W + TAU_W;
    localparam int PROD_W = EN_W + FACT_W;

    localparam logic [EN_W-1:0] UNIT_ENERGY = 16'd256;
    localparam logic [EN_W-1:0] ENERGY_MAX = 16'hFFFF;
    localparam logic [63:0] DECAY_STEP = 64'd4034748382;

    localparam logic [THR_W-1:0] THRESHOLD_RST = 16'd2560;
    localparam logic [TAU_W-1:0] INV_TAU_RST = 32'd42950;
    localparam logic [FSZ_W-1:0] FSZ_RST = 4'd5;
    localparam logic [FSZ_W-1:0] FSZ_MIN = 4'd5;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_INV_TAU = 2'd1;
    localparam logic [1:0] REG_FILTER_SIZE = 2'd2;

    typedef logic [FACT_W-1:0] decay_tab_t [256];

    // table of exp(-i/16) in q1.32, each entry one rounded step below the last
    function automatic decay_tab_t build_decay();
        decay_tab_t t;
        logic [64:0] p;
        t[0] = 33'h1_0000_0000;
        for (int i = 1; i < 256; i++)
        begin
            p = 65'(t[i-1]) * 65'(DECAY_STEP) + 65'h8000_0000;
            t[i] = p[64:32];
        end
        return t;
    endfunction

    localparam decay_tab_t DECAY_TAB = build_decay();

    typedef struct packed {
        logic load;
        logic clear_wr;
        logic rd;
        logic cap;
        logic mul;
        logic wr;
        logic chk_wr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic off;
        logic clear_last;
        logic last_cell;
        logic spike;
        logic out_free;
    } sts_t;

endpackage

[sv/event_lif_neuron_map_core.sv]
// event_lif_neuron_map_core: top level of the leaky integrate-and-fire
// neuron map: apb registers, elnm_ctrl and elnm_dp; uses elnm_pkg
//
// usage: address events (pos_x, pos_y, stamp) enter on in_valid/in_stall,
// a request is taken when in_valid is high and in_stall is low. each event
// updates a filter_size by filter_size patch of cells (side clamped to
// 5..MAX_FILTER), one cell at a time through a single memory (read,
// multiply dt*inv_tau, scale energy, write). events off the sensor are
// taken and dropped. a spike is a copy of the event on out_valid/out_stall;
// it sits in an output register, so the next event is taken while it
// waits, and only a second spike waits for the first to leave. after
// reset the cell memory is swept to zero, one cell a cycle over all
// (WIDTH+MAX_FILTER)*(HEIGHT+MAX_FILTER) cells, 97344 by default, with
// in_stall high; the apb registers take writes throughout, and the user
// must change them only while no event is in flight: the block itself
// does not enforce it.
`timescale 1ns / 1ps

module event_lif_neuron_map_core
    import elnm_pkg::*;
#(
    parameter int WIDTH = 304,
    parameter int HEIGHT = 304,
    parameter int MAX_FILTER = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [POS_W-1:0]   pos_x,
    input  logic [POS_W-1:0]   pos_y,
    input  logic [STAMP_W-1:0] stamp,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [POS_W-1:0]   spike_x,
    output logic [POS_W-1:0]   spike_y,
    output logic [STAMP_W-1:0] spike_stamp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [THR_W-1:0] threshold_reg;
    logic [TAU_W-1:0] inv_tau_reg;
    logic [FSZ_W-1:0] filter_size_reg;
    logic             cfg_wr;
    cmd_t             cmd;
    sts_t             sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            inv_tau_reg <= INV_TAU_RST;
            filter_size_reg <= FSZ_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_THRESHOLD:   threshold_reg <= pwdata[THR_W-1:0];
                REG_INV_TAU:     inv_tau_reg <= pwdata;
                REG_FILTER_SIZE: filter_size_reg <= pwdata[FSZ_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_THRESHOLD:   prdata = {16'b0, threshold_reg};
            REG_INV_TAU:     prdata = inv_tau_reg;
            REG_FILTER_SIZE: prdata = {28'b0, filter_size_reg};
            default:         prdata = '0;
        endcase
    end

    elnm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    elnm_dp #(
        .WIDTH      (WIDTH),
        .HEIGHT     (HEIGHT),
        .MAX_FILTER (MAX_FILTER)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .stamp       (stamp),
        .threshold   (threshold_reg),
        .inv_tau     (inv_tau_reg),
        .filter_size (filter_size_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .spike_x     (spike_x),
        .spike_y     (spike_y),
        .spike_stamp (spike_stamp)
    );

endmodule

[sv/elnm_ram.sv]
// elnm_ram: generic simple dual port ram, one write and one registered read
// no dependencies
`timescale 1ns / 1ps

module elnm_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/elnm_ctrl.sv]
// elnm_ctrl: sequencer of the neuron map, clearing pass then per cell
// read, decay, write, then the spike check; uses elnm_pkg
`timescale 1ns / 1ps

module elnm_ctrl
    import elnm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD = 3'd2;
    localparam logic [2:0] S_WT = 3'd3;
    localparam logic [2:0] S_MUL = 3'd4;
    localparam logic [2:0] S_WR = 3'd5;
    localparam logic [2:0] S_CHK = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (!sts.off)
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                cmd.rd = 1'b1;
                state_next = S_WT;
            end
            S_WT:
            begin
                cmd.cap = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd.wr = 1'b1;
                state_next = sts.last_cell ? S_CHK : S_RD;
            end
            S_CHK:
            begin
                if (sts.spike)
                begin
                    cmd.chk_wr = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // once the clearing pass ends it never restarts without reset
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_CLEAR |=> state_reg != S_CLEAR)
        else $error("clearing pass re-entered");

    a_last_cell: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WR && sts.last_cell |=> state_reg == S_CHK)
        else $error("patch end did not lead to spike check");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("spike overwrote a pending result");

    a_rd_seq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |=> cmd.cap ##1 cmd.mul ##1 cmd.wr)
        else $error("cell read-modify-write sequence broken");

endmodule

[sv/elnm_dp.sv]
// elnm_dp: datapath of the neuron map: cell memory, patch counters,
// decay arithmetic and the output register; uses elnm_pkg and elnm_ram
`timescale 1ns / 1ps

module elnm_dp
    import elnm_pkg::*;
#(
    parameter int WIDTH = 304,
    parameter int HEIGHT = 304,
    parameter int MAX_FILTER = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [POS_W-1:0]   pos_x,
    input  logic [POS_W-1:0]   pos_y,
    input  logic [STAMP_W-1:0] stamp,
    input  logic [THR_W-1:0]   threshold,
    input  logic [TAU_W-1:0]   inv_tau,
    input  logic [FSZ_W-1:0]   filter_size,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [POS_W-1:0]   spike_x,
    output logic [POS_W-1:0]   spike_y,
    output logic [STAMP_W-1:0] spike_stamp
);

    localparam int MAP_W = WIDTH + MAX_FILTER;
    localparam int MAP_CELLS = MAP_W * (HEIGHT + MAX_FILTER);
    localparam int ADDR_W = $clog2(MAP_CELLS);
    localparam int CNT_W = $clog2(MAX_FILTER + 1);
    localparam int WORD_W = STAMP_W + EN_W;

    logic [POS_W-1:0]   px_reg;
    logic [POS_W-1:0]   py_reg;
    logic [STAMP_W-1:0] now_reg;
    logic [CNT_W-1:0]   fs_reg;
    logic [CNT_W-1:0]   xi_reg;
    logic [CNT_W-1:0]   yi_reg;
    logic [ADDR_W-1:0]  row_base_reg;
    logic [ADDR_W-1:0]  centre_addr_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [EN_W-1:0]    e_reg;
    logic [SCALE_W-1:0] scaled_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [EN_W-1:0]    centre_e_reg;
    logic               out_valid_reg;
    logic [POS_W-1:0]   spike_x_reg;
    logic [POS_W-1:0]   spike_y_reg;
    logic [STAMP_W-1:0] spike_stamp_reg;

    logic [4:0]         fsz_ext;
    logic [CNT_W-1:0]   fs_clamp;
    logic [ADDR_W-1:0]  cell_addr;
    logic [WORD_W-1:0]  rdata;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [WORD_W-1:0]  wdata;
    logic [STAMP_W-1:0] dt;
    logic [FACT_W-1:0]  factor;
    logic [EN_W:0]      e_dec;
    logic [EN_W+1:0]    e_sum;
    logic [EN_W-1:0]    e_new;
    logic               first_cell;
    logic               row_end;

    always_comb
    begin
        fsz_ext = {1'b0, filter_size};
        priority if (fsz_ext < {1'b0, FSZ_MIN})
        begin
            fs_clamp = CNT_W'(FSZ_MIN);
        end
        else if (fsz_ext > 5'(MAX_FILTER))
        begin
            fs_clamp = CNT_W'(MAX_FILTER);
        end
        else
        begin
            fs_clamp = CNT_W'(fsz_ext);
        end
    end

    assign cell_addr = row_base_reg + ADDR_W'(px_reg) + ADDR_W'(xi_reg);
    assign first_cell = (xi_reg == '0) && (yi_reg == '0);
    assign row_end = (xi_reg == fs_reg - 1'b1);

    assign dt = now_reg - rdata[WORD_W-1:EN_W];
    // slot of 256 or more means full decay to zero
    assign factor = (|scaled_reg[SCALE_W-1:36]) ? '0 : DECAY_TAB[scaled_reg[35:28]];
    assign e_dec = prod_reg[PROD_W-1:32] + {{EN_W{1'b0}}, prod_reg[31]};
    assign e_sum = {1'b0, e_dec} + {2'b0, UNIT_ENERGY};
    assign e_new = (e_sum > {2'b0, ENERGY_MAX}) ? ENERGY_MAX : e_sum[EN_W-1:0];

    always_comb
    begin
        we = 1'b0;
        waddr = cell_addr;
        wdata = {now_reg, e_new};
        priority if (cmd.clear_wr)
        begin
            we = 1'b1;
            waddr = clr_addr_reg;
            wdata = '0;
        end
        else if (cmd.chk_wr)
        begin
            we = 1'b1;
            waddr = centre_addr_reg;
            wdata = {now_reg, {EN_W{1'b0}}};
        end
        else if (cmd.wr)
        begin
            we = 1'b1;
        end
        else
        begin
            we = 1'b0;
        end
    end

    elnm_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (MAP_CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (cell_addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
            now_reg <= stamp;
            fs_reg <= fs_clamp;
            xi_reg <= '0;
            yi_reg <= '0;
            row_base_reg <= ADDR_W'(32'(pos_y) * MAP_W);
            centre_addr_reg <= ADDR_W'(32'(pos_y) * MAP_W + 32'(pos_x));
        end
        if (cmd.cap)
        begin
            e_reg <= rdata[EN_W-1:0];
            scaled_reg <= SCALE_W'(dt) * SCALE_W'(inv_tau);
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(e_reg) * PROD_W'(factor);
        end
        if (cmd.wr)
        begin
            if (first_cell)
            begin
                centre_e_reg <= e_new;
            end
            if (row_end)
            begin
                xi_reg <= '0;
                yi_reg <= yi_reg + 1'b1;
                row_base_reg <= row_base_reg + ADDR_W'(MAP_W);
            end
            else
            begin
                xi_reg <= xi_reg + 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            spike_x_reg <= px_reg;
            spike_y_reg <= py_reg;
            spike_stamp_reg <= now_reg;
        end
    end

    assign sts.off = (32'(pos_x) >= WIDTH) || (32'(pos_y) >= HEIGHT);
    assign sts.clear_last = (32'(clr_addr_reg) == MAP_CELLS - 1);
    assign sts.last_cell = row_end && (yi_reg == fs_reg - 1'b1);
    assign sts.spike = (centre_e_reg > threshold);
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign spike_x = spike_x_reg;
    assign spike_y = spike_y_reg;
    assign spike_stamp = spike_stamp_reg;

endmodule

[sim/tb_top.sv]
// tb_top: self-checking testbench of event_lif_neuron_map_core
// drives address events and apb register writes, predicts spikes with a
// cell map model of its own; depends on elnm_pkg and the core
`timescale 1ns / 1ps

module tb_top;
    import elnm_pkg::*;

    localparam int SENSOR_W = 304;
    localparam int SENSOR_H = 304;
    localparam int PAD = 8;
    localparam int MAP_W = SENSOR_W + PAD;
    localparam int MAP_CELLS = MAP_W * (SENSOR_H + PAD);
    localparam int SETTLE_CYCLES = 600;
    localparam int unsigned CYCLE_LIMIT = 4000000;

    typedef struct {
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [STAMP_W-1:0] t;
    } spike_t;

    class spike_scoreboard;
        bit [EN_W-1:0]    energy [MAP_CELLS];
        bit [STAMP_W-1:0] last_seen [MAP_CELLS];
        bit [64:0]        decay [256];
        bit [THR_W-1:0]   thr;
        bit [TAU_W-1:0]   tau;
        bit [FSZ_W-1:0]   side;
        spike_t           pending_spikes [$];
        int               errors;

        function new();
            decay[0] = 65'h1_0000_0000;
            for (int i = 1; i < 256; i++)
                decay[i] = (decay[i-1] * 65'd4034748382 + 65'h8000_0000) >> 32;
            thr = 16'd2560;
            tau = 32'd42950;
            side = 4'd5;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_THRESHOLD:   thr = val[THR_W-1:0];
                REG_INV_TAU:     tau = val;
                REG_FILTER_SIZE: side = val[FSZ_W-1:0];
                default: ;
            endcase
        endfunction

        // leak, inject one unit, stamp the cell
        function void leak_cell(int idx, bit [STAMP_W-1:0] now);
            bit [STAMP_W-1:0] dt;
            bit [55:0] scaled;
            bit [64:0] factor;
            bit [64:0] e;
            dt = now - last_seen[idx];
            scaled = 56'(dt) * 56'(tau);
            factor = (scaled[55:28] < 256) ? decay[scaled[35:28]] : 65'd0;
            e = ((65'(energy[idx]) * factor + 65'h8000_0000) >> 32) + 65'd256;
            energy[idx] = (e > 65'd65535) ? 16'hFFFF : e[15:0];
            last_seen[idx] = now;
        endfunction

        function void note_event(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                 logic [STAMP_W-1:0] t);
            int fs;
            int centre;
            spike_t s;
            if (x >= SENSOR_W || y >= SENSOR_H)
                return;
            fs = (side < 5) ? 5 : (side > PAD) ? PAD : side;
            for (int yi = 0; yi < fs; yi++)
                for (int xi = 0; xi < fs; xi++)
                    leak_cell((y + yi) * MAP_W + x + xi, t);
            centre = y * MAP_W + x;
            if (energy[centre] > thr)
            begin
                energy[centre] = '0;
                s.x = x;
                s.y = y;
                s.t = t;
                pending_spikes.push_back(s);
            end
        endfunction

        function void check_spike(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                  logic [STAMP_W-1:0] t);
            spike_t s;
            if (pending_spikes.size() == 0)
            begin
                $display("%0t: unexpected spike x=%0d y=%0d stamp=%0d", $time, x, y, t);
                errors++;
                return;
            end
            s = pending_spikes.pop_front();
            if (s.x !== x || s.y !== y || s.t !== t)
            begin
                $display("%0t: spike mismatch expected x=%0d y=%0d stamp=%0d",
                         $time, s.x, s.y, s.t);
                $display("%0t:                got x=%0d y=%0d stamp=%0d",
                         $time, x, y, t);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [STAMP_W-1:0] stamp;
    logic               out_valid;
    logic               out_stall;
    logic [POS_W-1:0]   spike_x;
    logic [POS_W-1:0]   spike_y;
    logic [STAMP_W-1:0] spike_stamp;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    spike_scoreboard    sb;
    int                 idle_pct;
    int                 stall_pct;
    int                 hold_left;
    int unsigned        cycles;
    logic [STAMP_W-1:0] now_us;

    event_lif_neuron_map_core DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .pos_x(pos_x), .pos_y(pos_y), .stamp(stamp),
        .out_valid(out_valid), .out_stall(out_stall),
        .spike_x(spike_x), .spike_y(spike_y), .spike_stamp(spike_stamp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // spike side: check, then pick the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_spike(spike_x, spike_y, spike_stamp);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_event(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                              logic [STAMP_W-1:0] t);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x <= x;
        pos_y <= y;
        stamp <= t;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_event(x, y, t);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    // registers change only once the core has gone quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_spikes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(logic [15:0] thr, logic [31:0] tau, logic [3:0] fs,
                             int idle, int stall, int count, bit squeeze);
        int bx;
        int by;
        int pick;
        drain();
        write_reg(REG_THRESHOLD, 32'(thr));
        write_reg(REG_INV_TAU, tau);
        write_reg(REG_FILTER_SIZE, 32'(fs));
        idle_pct = idle;
        stall_pct = stall;
        bx = $urandom_range(SENSOR_W - 12);
        by = $urandom_range(SENSOR_H - 12);
        for (int n = 0; n < count; n++)
        begin
            if (squeeze && n == 10)
                hold_left = 3000;
            if (n % 60 == 59)
            begin
                bx = $urandom_range(SENSOR_W - 12);
                by = $urandom_range(SENSOR_H - 12);
            end
            pick = $urandom_range(99);
            if (pick < 3)
                now_us = STAMP_W'($urandom);
            else
                now_us += STAMP_W'($urandom_range(pick < 10 ? 60000 : 400));
            if (pick < 85)
                send_event(POS_W'(bx + $urandom_range(11)), POS_W'(by + $urandom_range(11)),
                           now_us);
            else if (pick < 95)
                send_event(POS_W'($urandom_range(SENSOR_W - 1)),
                           POS_W'($urandom_range(SENSOR_H - 1)), now_us);
            else
                send_event(POS_W'($urandom_range(511)),
                           POS_W'($urandom_range(SENSOR_W, 511)), now_us);
        end
    endtask

    initial
    begin
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        pos_x = '0;
        pos_y = '0;
        stamp = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        cycles = 0;
        now_us = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: corners, off-sensor, stamp extremes and wrap, repeated hits
        send_event(9'd0, 9'd0, 24'd0);
        send_event(9'd303, 9'd303, 24'hFFFFFF);
        send_event(9'd303, 9'd0, 24'd5);
        send_event(9'd0, 9'd303, 24'd7);
        send_event(9'd304, 9'd0, 24'd9);
        send_event(9'd0, 9'd304, 24'd9);
        send_event(9'd511, 9'd511, 24'd9);
        send_event(9'd100, 9'd100, 24'hFFFFF0);
        for (int i = 0; i < 12; i++)
            send_event(9'd100, 9'd100, 24'h10 + 24'(i * 3));
        send_event(9'd303, 9'd303, 24'd40);

        run_phase(16'd2560, 32'd42950, 4'd5, 0, 0, 200, 1'b0);
        run_phase(16'd0, 32'hFFFFFFFF, 4'd8, 49, 0, 200, 1'b0);
        run_phase(16'd0, 32'd1, 4'd6, 0, 0, 150, 1'b1);
        run_phase(16'd1500, 32'h0080_0000, 4'd7, 0, 49, 200, 1'b0);
        run_phase(16'hFFFF, 32'd0, 4'd15, 6, 6, 150, 1'b0);
        run_phase(16'd600, 32'h0004_0000, 4'd0, 49, 0, 200, 1'b0);
        run_phase(16'd2000, 32'd1000000, 4'd5, 0, 49, 200, 1'b0);
        run_phase(16'd800, 32'h0100_0000, 4'd8, 6, 6, 200, 1'b0);

        drain();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
sv/elnm_pkg.sv
sv/elnm_ram.sv
sv/elnm_ctrl.sv
sv/elnm_dp.sv
sv/event_lif_neuron_map_core.sv
sim/tb_top.sv
